### rtl/lpbws_pkg.sv
// Shared types and constants for the parallel LCD bus write sequencer.
// No dependencies; imported by every module of the block.
package lpbws_pkg;

  // Request codes on the input channel.
  typedef enum logic [1:0] {
    REQ_PIXEL  = 2'd0,
    REQ_WINDOW = 2'd1,
    REQ_CURSOR = 2'd2,
    REQ_ORIENT = 2'd3
  } req_t;

  // Pixel format register codes. Code 3 is unused and behaves as 16bpp.
  typedef enum logic [1:0] {
    FMT_16BPP = 2'd0,
    FMT_18BPP = 2'd1,
    FMT_LATCH = 2'd2,
    FMT_SPARE = 2'd3
  } fmt_t;

  // Kind of one bus cycle.
  typedef enum logic [1:0] {
    KIND_INDEX = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_LATCH = 2'd2
  } kind_t;

  // Classified operation carried from the front to the back.
  typedef enum logic [2:0] {
    OP_PIX16  = 3'd0,
    OP_PIX18  = 3'd1,
    OP_PIXL   = 3'd2,
    OP_WIN    = 3'd3,
    OP_CUR    = 3'd4,
    OP_ORIENT = 3'd5
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] color;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic [7:0]  mode_val;
  } desc_t;

  localparam logic [7:0] REG_WIN_BASE   = 8'h02;
  localparam logic [7:0] IDX_GRAM       = 8'h22;
  localparam logic [7:0] REG_MEM_ACCESS = 8'h16;
  localparam logic [7:0] MODE_LANDSCAPE = 8'h1C;
  localparam logic [7:0] MODE_PORTRAIT  = 8'hBC;

  localparam int FULL_WIDTH_MAX_DEF  = 399;
  localparam int FULL_HEIGHT_MAX_DEF = 239;
  localparam int QUEUE_DEPTH_DEF     = 2;

endpackage

### rtl/lcd_parallel_bus_write_sequencer_unit.sv
// Top level of the parallel LCD bus write sequencer.
// Instantiates lpbws_front, lpbws_queue and lpbws_back; uses lpbws_pkg.
//
//   Channel  Direction  Handshake                   Payload
//   in_      input      in_valid / in_ready         req_type, color, coords, portrait
//   out_     output     out_valid / out_ready       kind, bus_byte, last
//   cfg_     input      cfg_we (no wait)            pixel_format in cfg_wdata
//
// The back end emits one bus cycle per clock into an output register while the
// output is not stalled; a request is a run of bus cycles: a pixel 2 or 3, a
// cursor 9, a window 17 and an orientation change 19.
// Requests are classified on acceptance and queued, so intake continues
// while the output stalls until the queue is full.
// Reset clears the queue, the output stage, orientation and pixel format.
module lcd_parallel_bus_write_sequencer_unit
  import lpbws_pkg::*;
#(
  parameter int FULL_WIDTH_MAX  = FULL_WIDTH_MAX_DEF,
  parameter int FULL_HEIGHT_MAX = FULL_HEIGHT_MAX_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_color,
  input  logic [15:0] in_x_start,
  input  logic [15:0] in_y_start,
  input  logic [15:0] in_x_end,
  input  logic [15:0] in_y_end,
  input  logic        in_portrait,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_bus_byte,
  output logic        out_last
);

  desc_t new_desc;
  desc_t head;
  logic  q_full;
  logic  head_valid;
  logic  pop;
  logic  accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  lpbws_front #(
    .FULL_WIDTH_MAX (FULL_WIDTH_MAX),
    .FULL_HEIGHT_MAX(FULL_HEIGHT_MAX)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .req_type (in_req_type),
    .color    (in_color),
    .x_start  (in_x_start),
    .y_start  (in_y_start),
    .x_end    (in_x_end),
    .y_end    (in_y_end),
    .portrait (in_portrait),
    .desc     (new_desc)
  );

  lpbws_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_desc (new_desc),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  lpbws_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_bus_byte(out_bus_byte),
    .out_last    (out_last)
  );

endmodule

### rtl/lpbws_front.sv
// Front end: accepts requests, holds the pixel format and orientation,
// and turns each request into a descriptor for the queue. Uses lpbws_pkg.
module lpbws_front
  import lpbws_pkg::*;
#(
  parameter int FULL_WIDTH_MAX  = FULL_WIDTH_MAX_DEF,
  parameter int FULL_HEIGHT_MAX = FULL_HEIGHT_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        accept,
  input  logic [1:0]  req_type,
  input  logic [15:0] color,
  input  logic [15:0] x_start,
  input  logic [15:0] y_start,
  input  logic [15:0] x_end,
  input  logic [15:0] y_end,
  input  logic        portrait,
  output desc_t       desc
);

  fmt_t fmt_r;
  logic orient_r;

  localparam logic [15:0] FullW = 16'(FULL_WIDTH_MAX);
  localparam logic [15:0] FullH = 16'(FULL_HEIGHT_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_16BPP;
      orient_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fmt_r <= fmt_t'(cfg_wdata);
      end
      if (accept && (req_t'(req_type) == REQ_ORIENT)) begin
        orient_r <= portrait;
      end
    end
  end

  always_comb begin
    desc          = '0;
    desc.color    = color;
    desc.mode_val = portrait ? MODE_PORTRAIT : MODE_LANDSCAPE;
    case (req_t'(req_type))
      REQ_PIXEL: begin
        case (fmt_r)
          FMT_18BPP: desc.op = OP_PIX18;
          FMT_LATCH: desc.op = OP_PIXL;
          default:   desc.op = OP_PIX16;
        endcase
      end
      REQ_WINDOW: begin
        desc.op = OP_WIN;
        if (orient_r) begin
          desc.x0 = y_start;
          desc.y0 = x_start;
          desc.x1 = y_end;
          desc.y1 = x_end;
        end else begin
          desc.x0 = x_start;
          desc.y0 = y_start;
          desc.x1 = x_end;
          desc.y1 = y_end;
        end
      end
      REQ_CURSOR: begin
        desc.op = OP_CUR;
        desc.x0 = x_start;
        desc.y0 = y_start;
      end
      default: begin
        // The full-screen window uses the orientation being set.
        desc.op = OP_ORIENT;
        desc.x0 = 16'd0;
        desc.y0 = 16'd0;
        desc.x1 = portrait ? FullH : FullW;
        desc.y1 = portrait ? FullW : FullH;
      end
    endcase
  end

endmodule

### rtl/lpbws_queue.sv
// Short descriptor queue between the front and the back.
// Uses the desc_t type from lpbws_pkg.
module lpbws_queue
  import lpbws_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  desc_t           slots_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;

  assign full       = (count_r == FullCnt);
  assign head_valid = (count_r != '0);
  assign head       = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_desc;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FullCnt)
    else $error("queue count above depth");

  a_pop_only_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

### rtl/lpbws_back.sv
// Back end: walks the head descriptor one bus cycle per clock into a registered
// output stage, while that stage is not stalled. Uses lpbws_pkg.
module lpbws_back
  import lpbws_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  desc_t      head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_bus_byte,
  output logic       out_last
);

  logic [4:0] step_r, step_nxt;
  logic [4:0] last_step;
  logic [4:0] w;
  logic [2:0] pair;
  logic [7:0] coord_byte;
  logic       is_last;
  logic       fire;
  kind_t      kind_c;
  logic [7:0] byte_c;

  logic       out_valid_r;
  kind_t      out_kind_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  always_comb begin
    case (head.op)
      OP_PIX16:  last_step = 5'd1;
      OP_PIXL:   last_step = 5'd1;
      OP_PIX18:  last_step = 5'd2;
      OP_WIN:    last_step = 5'd16;
      OP_CUR:    last_step = 5'd8;
      OP_ORIENT: last_step = 5'd18;
      default:   last_step = 5'd1;
    endcase
  end

  assign is_last = (step_r == last_step);
  assign fire    = head_valid && (!out_valid_r || out_ready);
  assign pop     = fire && is_last;

  // Window-like runs: an orientation change leads with a memory-access index and data.
  always_comb begin
    w    = (head.op == OP_ORIENT) ? step_r - 5'd2 : step_r;
    // A cursor run uses register pairs 0, 1, 4 and 5 of the window run.
    pair = (head.op == OP_CUR) ? {w[2], 1'b0, w[1]} : w[3:1];
    case (pair)
      3'd0:    coord_byte = head.y0[15:8];
      3'd1:    coord_byte = head.y0[7:0];
      3'd2:    coord_byte = head.y1[15:8];
      3'd3:    coord_byte = head.y1[7:0];
      3'd4:    coord_byte = head.x0[15:8];
      3'd5:    coord_byte = head.x0[7:0];
      3'd6:    coord_byte = head.x1[15:8];
      default: coord_byte = head.x1[7:0];
    endcase
  end

  always_comb begin
    kind_c = KIND_DATA;
    byte_c = '0;
    case (head.op)
      OP_PIX16: begin
        byte_c = (step_r == 5'd0) ? head.color[15:8] : head.color[7:0];
      end
      OP_PIXL: begin
        if (step_r == 5'd0) begin
          kind_c = KIND_LATCH;
          byte_c = head.color[15:8];
        end else begin
          byte_c = head.color[7:0];
        end
      end
      OP_PIX18: begin
        case (step_r[1:0])
          2'd0:    byte_c = {head.color[15:11], 3'b000};
          2'd1:    byte_c = {head.color[10:5], 2'b00};
          default: byte_c = {head.color[4:0], 3'b000};
        endcase
      end
      default: begin
        if ((head.op == OP_ORIENT) && (step_r == 5'd0)) begin
          kind_c = KIND_INDEX;
          byte_c = REG_MEM_ACCESS;
        end else if ((head.op == OP_ORIENT) && (step_r == 5'd1)) begin
          byte_c = head.mode_val;
        end else if (is_last) begin
          kind_c = KIND_INDEX;
          byte_c = IDX_GRAM;
        end else if (!w[0]) begin
          kind_c = KIND_INDEX;
          byte_c = REG_WIN_BASE + {5'd0, pair};
        end else begin
          byte_c = coord_byte;
        end
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (fire) begin
      step_nxt = is_last ? 5'd0 : step_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_kind_r <= kind_c;
      out_byte_r <= byte_c;
      out_last_r <= is_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_bus_byte = out_byte_r;
  assign out_last     = out_last_r;

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (step_r <= last_step))
    else $error("step counter beyond end of run");

  a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> (step_r == 5'd0))
    else $error("step counter not at start with queue empty");

endmodule

### bench/lcd_parallel_bus_write_sequencer_unit_tb.sv
// Testbench for the parallel LCD bus write sequencer: directed and random requests,
// a local model of the bus-cycle runs, and in-order checking of every result item.
// Depends on lpbws_pkg and lcd_parallel_bus_write_sequencer_unit.
module lcd_parallel_bus_write_sequencer_unit_tb;
  import lpbws_pkg::*;

  localparam int WIDTH_MAX     = FULL_WIDTH_MAX_DEF;
  localparam int HEIGHT_MAX    = FULL_HEIGHT_MAX_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  bus_byte;
    logic        last;
  } bus_cycle_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [1:0]  cfg_wdata   = 2'b00;
  logic        in_valid    = 1'b0;
  logic [1:0]  in_req_type = 2'b00;
  logic [15:0] in_color    = 16'h0000;
  logic [15:0] in_x_start  = 16'h0000;
  logic [15:0] in_y_start  = 16'h0000;
  logic [15:0] in_x_end    = 16'h0000;
  logic [15:0] in_y_end    = 16'h0000;
  logic        in_portrait = 1'b0;
  logic        out_ready   = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_bus_byte;
  logic        out_last;

  // Mirror of the block's state: orientation is updated as items are accepted, pixel format as it is written.
  fmt_t        fmt_model    = FMT_16BPP;
  logic        orient_model = 1'b0;
  bus_cycle_t  bus_cycles_due[$];

  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          hold_len       = 0;
  bit          source_idle    = 1'b1;
  bit          sink_idle      = 1'b1;

  lcd_parallel_bus_write_sequencer_unit #(
    .FULL_WIDTH_MAX (WIDTH_MAX),
    .FULL_HEIGHT_MAX(HEIGHT_MAX)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_color    (in_color),
    .in_x_start  (in_x_start),
    .in_y_start  (in_y_start),
    .in_x_end    (in_x_end),
    .in_y_end    (in_y_end),
    .in_portrait (in_portrait),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_bus_byte(out_bus_byte),
    .out_last    (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void add_cycle(kind_t k, logic [7:0] b);
    bus_cycle_t c;
    c.kind     = k;
    c.bus_byte = b;
    c.last     = 1'b0;
    bus_cycles_due.push_back(c);
  endfunction

  function automatic void add_reg(logic [7:0] idx, logic [7:0] val);
    add_cycle(KIND_INDEX, idx);
    add_cycle(KIND_DATA, val);
  endfunction

  // In portrait the controller's axes are swapped relative to the caller's.
  function automatic void add_window(logic [15:0] xs, logic [15:0] ys,
                                     logic [15:0] xe, logic [15:0] ye);
    logic [15:0] x0, y0, x1, y1;
    x0 = xs; y0 = ys; x1 = xe; y1 = ye;
    if (orient_model) begin
      x0 = ys; y0 = xs; x1 = ye; y1 = xe;
    end
    add_reg(REG_WIN_BASE,         y0[15:8]);
    add_reg(REG_WIN_BASE + 8'd1,  y0[7:0]);
    add_reg(REG_WIN_BASE + 8'd2,  y1[15:8]);
    add_reg(REG_WIN_BASE + 8'd3,  y1[7:0]);
    add_reg(REG_WIN_BASE + 8'd4,  x0[15:8]);
    add_reg(REG_WIN_BASE + 8'd5,  x0[7:0]);
    add_reg(REG_WIN_BASE + 8'd6,  x1[15:8]);
    add_reg(REG_WIN_BASE + 8'd7,  x1[7:0]);
    add_cycle(KIND_INDEX, IDX_GRAM);
  endfunction

  function automatic void predict_bus_run(req_t req, logic [15:0] color,
                                          logic [15:0] xs, logic [15:0] ys,
                                          logic [15:0] xe, logic [15:0] ye,
                                          logic port);
    case (req)
      REQ_PIXEL: begin
        case (fmt_model)
          FMT_18BPP: begin
            add_cycle(KIND_DATA, {color[15:11], 3'b000});
            add_cycle(KIND_DATA, {color[10:5], 2'b00});
            add_cycle(KIND_DATA, {color[4:0], 3'b000});
          end
          FMT_LATCH: begin
            add_cycle(KIND_LATCH, color[15:8]);
            add_cycle(KIND_DATA, color[7:0]);
          end
          default: begin
            add_cycle(KIND_DATA, color[15:8]);
            add_cycle(KIND_DATA, color[7:0]);
          end
        endcase
      end
      REQ_WINDOW: add_window(xs, ys, xe, ye);
      REQ_CURSOR: begin
        // The cursor registers are never swapped, whatever the orientation.
        add_reg(REG_WIN_BASE,        ys[15:8]);
        add_reg(REG_WIN_BASE + 8'd1, ys[7:0]);
        add_reg(REG_WIN_BASE + 8'd4, xs[15:8]);
        add_reg(REG_WIN_BASE + 8'd5, xs[7:0]);
        add_cycle(KIND_INDEX, IDX_GRAM);
      end
      default: begin
        add_reg(REG_MEM_ACCESS, port ? MODE_PORTRAIT : MODE_LANDSCAPE);
        orient_model = port;
        add_window(16'd0, 16'd0, 16'(WIDTH_MAX), 16'(HEIGHT_MAX));
      end
    endcase
    bus_cycles_due[bus_cycles_due.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      predict_bus_run(req_t'(in_req_type), in_color, in_x_start, in_y_start,
                      in_x_end, in_y_end, in_portrait);
  end

  always @(posedge clk) begin : check_results
    bus_cycle_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bus_cycles_due.size() == 0) begin
        $error("unexpected result item: kind %0d bus_byte 0x%02h last %0b",
               out_kind, out_bus_byte, out_last);
        mismatch_count++;
      end else begin
        want = bus_cycles_due.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_kind);
          mismatch_count++;
        end
        if (out_bus_byte !== want.bus_byte) begin
          $error("bus_byte: expected 0x%02h, actual 0x%02h", want.bus_byte, out_bus_byte);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  // Result side: a random stall before each item while sink_idle is set, and a long hold-off on request.
  initial begin : result_sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      stall = sink_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(req_t req, logic [15:0] color, logic [15:0] xs,
                           logic [15:0] ys, logic [15:0] xe, logic [15:0] ye,
                           logic port);
    int gap;
    gap = source_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_color    <= color;
    in_x_start  <= xs;
    in_y_start  <= ys;
    in_x_end    <= xe;
    in_y_end    <= ye;
    in_portrait <= port;
    do @(posedge clk); while (!in_ready);
  endtask

  // Extremes and small values are favored so that the high bytes often vary.
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 511));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_item();
    int   pick;
    req_t req;
    pick = $urandom_range(0, 9);
    if (pick < 5)      req = REQ_PIXEL;
    else if (pick < 7) req = REQ_WINDOW;
    else if (pick < 8) req = REQ_CURSOR;
    else               req = REQ_ORIENT;
    send_item(req, 16'($urandom), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              1'($urandom));
  endtask

  // Stops offering items, waits for every expected result, then lets the block settle.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bus_cycles_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pixel_format(fmt_t fmt);
    cfg_we    <= 1'b1;
    cfg_wdata <= fmt;
    @(posedge clk);
    cfg_we    <= 1'b0;
    fmt_model = fmt;
  endtask

  task automatic test_pixel_formats();
    fmt_t fmts[4] = '{FMT_16BPP, FMT_18BPP, FMT_LATCH, FMT_SPARE};
    foreach (fmts[i]) begin
      set_pixel_format(fmts[i]);
      // Unused fields are set to the opposite extreme; they must not matter.
      send_item(REQ_PIXEL, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_item(REQ_PIXEL, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      wait_drain();
    end
  endtask

  task automatic test_window_and_cursor();
    send_item(REQ_WINDOW, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(REQ_WINDOW, 16'hFFFF, 16'hFFFF, 16'h1234, 16'h0000, 16'hABCD, 1'b0);
    send_item(REQ_CURSOR, 16'h5A5A, 16'hFFFF, 16'h0000, 16'h1111, 16'h2222, 1'b1);
    send_item(REQ_CURSOR, 16'hA5A5, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    wait_drain();
  endtask

  task automatic test_orientation();
    send_item(REQ_ORIENT, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(REQ_WINDOW, 16'h0000, 16'h0102, 16'h0304, 16'h0506, 16'h0708, 1'b0);
    send_item(REQ_CURSOR, 16'h0000, 16'h1234, 16'h5678, 16'h0000, 16'h0000, 1'b0);
    send_item(REQ_ORIENT, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_item(REQ_ORIENT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_item(REQ_WINDOW, 16'h0000, 16'h0102, 16'h0304, 16'h0506, 16'h0708, 1'b1);
    wait_drain();
  endtask

  task automatic test_random(int n_items);
    fmt_t fmts[4] = '{FMT_LATCH, FMT_16BPP, FMT_SPARE, FMT_18BPP};
    foreach (fmts[i]) begin
      set_pixel_format(fmts[i]);
      for (int k = 0; k < n_items / 4; k++) begin
        // Switch idling on and off in stretches so that some runs are back to back.
        if (k % 16 == 0) begin
          source_idle = ($urandom_range(0, 3) != 0);
          sink_idle   = ($urandom_range(0, 3) != 0);
        end
        send_random_item();
      end
      wait_drain();
    end
    source_idle = 1'b1;
    sink_idle   = 1'b1;
  endtask

  // The result side holds off while items keep coming, so the queue fills up.
  task automatic test_backpressure();
    source_idle = 1'b0;
    hold_len    = HOLD_CYCLES;
    repeat (12) send_random_item();
    source_idle = 1'b1;
    wait_drain();
  endtask

  task automatic test_pause_until_drained();
    repeat (4) begin
      repeat (3) send_random_item();
      wait_drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pixel_formats();
    test_window_and_cursor();
    test_orientation();
    test_random(240);
    test_backpressure();
    test_pause_until_drained();
    wait_drain();
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
